/* sv/b2da_pkg.sv */
package b2da_pkg;

    localparam int VALUE_W     = 16;
    localparam int NUM_DIGITS  = 5;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int PIPE_STAGES = 4;
    localparam int STAGE_STEPS = VALUE_W / PIPE_STAGES;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    // character positions within one value's text
    localparam logic [POS_W-1:0] POS_LEAD  = 3'd0;
    localparam logic [POS_W-1:0] POS_D4    = 3'd1;
    localparam logic [POS_W-1:0] POS_D3    = 3'd2;
    localparam logic [POS_W-1:0] POS_D2    = 3'd3;
    localparam logic [POS_W-1:0] POS_D1    = 3'd4;
    localparam logic [POS_W-1:0] POS_UNITS = 3'd5;
    localparam logic [POS_W-1:0] POS_TRAIL = 3'd6;

    localparam logic MODE_MINIMAL = 1'b0;
    localparam logic MODE_PADDED  = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } t_bcd_beat;

    // one shift-add-3 step
    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0] bcd,
        input logic             bit_in
    );
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [3:0] digit_at(
        input logic [BCD_W-1:0] bcd,
        input logic [POS_W-1:0] pos
    );
        logic [3:0] d;
        case (pos)
            POS_D4:    d = bcd[19:16];
            POS_D3:    d = bcd[15:12];
            POS_D2:    d = bcd[11:8];
            POS_D1:    d = bcd[7:4];
            POS_UNITS: d = bcd[3:0];
            default:   d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

/* sv/b2da_bcd_pipe.sv */
module b2da_bcd_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [b2da_pkg::VALUE_W-1:0]  i_value,
    output b2da_pkg::t_bcd_beat           o_beat,
    input  logic                          i_ready
);

    localparam int NS = b2da_pkg::PIPE_STAGES;

    logic                           r_vld [NS];
    logic [b2da_pkg::BCD_W-1:0]     r_bcd [NS];
    logic [b2da_pkg::VALUE_W-1:0]   r_bin [NS];

    logic                           s_vld [NS];
    logic [b2da_pkg::BCD_W-1:0]     s_bcd [NS];
    logic [b2da_pkg::VALUE_W-1:0]   s_bin [NS];
    logic [b2da_pkg::BCD_W-1:0]     n_bcd [NS];
    logic [b2da_pkg::VALUE_W-1:0]   n_bin [NS];
    logic                           advance [NS];

    always_comb begin
        s_vld[0] = i_valid;
        s_bcd[0] = '0;
        s_bin[0] = i_value;
        for (int i = 1; i < NS; i++) begin
            s_vld[i] = r_vld[i-1];
            s_bcd[i] = r_bcd[i-1];
            s_bin[i] = r_bin[i-1];
        end
    end

    always_comb begin
        logic [b2da_pkg::BCD_W-1:0]   bcd;
        logic [b2da_pkg::VALUE_W-1:0] bin;
        for (int i = 0; i < NS; i++) begin
            bcd = s_bcd[i];
            bin = s_bin[i];
            for (int s = 0; s < b2da_pkg::STAGE_STEPS; s++) begin
                bcd = b2da_pkg::dabble_step(bcd, bin[b2da_pkg::VALUE_W-1]);
                bin = {bin[b2da_pkg::VALUE_W-2:0], 1'b0};
            end
            n_bcd[i] = bcd;
            n_bin[i] = bin;
        end
    end

    always_comb begin
        advance[NS-1] = !r_vld[NS-1] || i_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            advance[i] = !r_vld[i] || advance[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (advance[i]) begin
                    r_vld[i] <= s_vld[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NS; i++) begin
            if (advance[i] && s_vld[i]) begin
                r_bcd[i] <= n_bcd[i];
                r_bin[i] <= n_bin[i];
            end
        end
    end

    assign o_ready      = advance[0];
    assign o_beat.valid = r_vld[NS-1];
    assign o_beat.bcd   = r_bcd[NS-1];

endmodule

/* sv/b2da_serializer.sv */
module b2da_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_format_mode,
    input  b2da_pkg::t_bcd_beat           i_beat,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);

    logic                           r_ser_valid, n_ser_valid;
    logic [b2da_pkg::POS_W-1:0]     r_pos, n_pos;
    logic                           r_mode;
    logic [b2da_pkg::BCD_W-1:0]     r_bcd;
    logic                           r_out_valid, n_out_valid;
    logic [b2da_pkg::CHAR_W-1:0]    r_char;
    logic                           r_last;

    logic                           out_free;
    logic                           emit;
    logic                           is_last;
    logic                           take;
    logic [b2da_pkg::POS_W-1:0]     start_pos;
    logic [b2da_pkg::CHAR_W-1:0]    cur_char;

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_ser_valid && out_free;
    assign is_last  = (r_mode == b2da_pkg::MODE_PADDED) ? (r_pos == b2da_pkg::POS_TRAIL)
                                                        : (r_pos == b2da_pkg::POS_UNITS);
    assign o_ready  = !r_ser_valid || (emit && is_last);
    assign take     = i_beat.valid && o_ready;

    // padded starts at the leading space; minimal at the first nonzero digit, else the units digit
    always_comb begin
        if (i_format_mode == b2da_pkg::MODE_PADDED) begin
            start_pos = b2da_pkg::POS_LEAD;
        end else if (i_beat.bcd[19:16] != 4'd0) begin
            start_pos = b2da_pkg::POS_D4;
        end else if (i_beat.bcd[15:12] != 4'd0) begin
            start_pos = b2da_pkg::POS_D3;
        end else if (i_beat.bcd[11:8] != 4'd0) begin
            start_pos = b2da_pkg::POS_D2;
        end else if (i_beat.bcd[7:4] != 4'd0) begin
            start_pos = b2da_pkg::POS_D1;
        end else begin
            start_pos = b2da_pkg::POS_UNITS;
        end
    end

    always_comb begin
        if (r_pos == b2da_pkg::POS_LEAD || r_pos == b2da_pkg::POS_TRAIL) begin
            cur_char = b2da_pkg::ASCII_SPACE;
        end else begin
            cur_char = b2da_pkg::ASCII_ZERO + {4'd0, b2da_pkg::digit_at(r_bcd, r_pos)};
        end
    end

    always_comb begin
        n_ser_valid = r_ser_valid;
        n_pos       = r_pos;
        if (take) begin
            n_ser_valid = 1'b1;
            n_pos       = start_pos;
        end else if (emit) begin
            n_pos = r_pos + 3'd1;
            if (is_last) begin
                n_ser_valid = 1'b0;
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_pos       <= b2da_pkg::POS_LEAD;
            r_out_valid <= 1'b0;
        end else begin
            r_ser_valid <= n_ser_valid;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode <= i_format_mode;
            r_bcd  <= i_beat.bcd;
        end
        if (emit) begin
            r_char <= cur_char;
            r_last <= is_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid |-> r_pos <= b2da_pkg::POS_TRAIL)
        else $error("serializer position out of range");

    a_minimal_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ser_valid && r_mode == b2da_pkg::MODE_MINIMAL) |->
            (r_pos != b2da_pkg::POS_LEAD && r_pos != b2da_pkg::POS_TRAIL))
        else $error("space position reached in minimal mode");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == b2da_pkg::ASCII_SPACE ||
                     (o_char_code >= b2da_pkg::ASCII_ZERO && o_char_code <= 8'h39)))
        else $error("character is neither a digit nor a space");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && is_last && !take) |=> !r_ser_valid)
        else $error("serializer still busy after last character");
`endif

endmodule

/* sv/binary_to_decimal_ascii_top.sv */
// A value reaches o_valid via the stage registers, serializer state and output register.
// Four double-dabble stages (4 shift steps each) feed a serializer and an output register.
// Throughput: one character per cycle unless i_ready stalls; a value gives 1 to 5
// characters in minimal mode and 7 in padded mode; the next value is taken with the last.
// Reset: i_rst_n synchronous, active low; clears all valid bits and format_mode.
module binary_to_decimal_ascii_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [b2da_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);

    logic                   r_format_mode;
    b2da_pkg::t_bcd_beat    bcd_beat;
    logic                   ser_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= b2da_pkg::MODE_MINIMAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_format_mode <= i_cfg_data;
        end
    end

    b2da_bcd_pipe u_bcd_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_beat  (bcd_beat),
        .i_ready (ser_ready)
    );

    b2da_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_format_mode (r_format_mode),
        .i_beat        (bcd_beat),
        .o_ready       (ser_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_code   (o_char_code),
        .o_last        (o_last)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic                          ch;
        logic [b2da_pkg::VALUE_W-1:0]  data;
        string                         text;
    } t_stim_row;

    typedef struct {
        logic [b2da_pkg::CHAR_W-1:0]   code;
        logic                          last;
    } t_char;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic                          i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    logic [b2da_pkg::VALUE_W-1:0]  i_value;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [b2da_pkg::CHAR_W-1:0]   o_char_code;
    logic                          o_last;

    t_char     chars_due[$];
    t_stim_row dir_rows[$];
    logic      fmt_mode;
    bit        calm;
    int        errors;
    int        values_sent;
    int        chars_checked;
    int        cfg_writes;
    int        stall_left;
    int        sink_draw;

    binary_to_decimal_ascii_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d characters still due", $time, chars_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // decimal text of one value under the current format
    function automatic void predict_text(input logic [b2da_pkg::VALUE_W-1:0] v,
                                         input logic mode);
        logic [3:0] dig [b2da_pkg::NUM_DIGITS];
        int         pw;
        int         lead;
        pw = 10000;
        for (int k = 0; k < b2da_pkg::NUM_DIGITS; k++) begin
            dig[k] = 4'((int'(v) / pw) % 10);
            pw = pw / 10;
        end
        if (mode == b2da_pkg::MODE_PADDED) begin
            chars_due.push_back('{b2da_pkg::ASCII_SPACE, 1'b0});
            for (int k = 0; k < b2da_pkg::NUM_DIGITS; k++) begin
                chars_due.push_back('{b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(dig[k]), 1'b0});
            end
            chars_due.push_back('{b2da_pkg::ASCII_SPACE, 1'b1});
        end else begin
            lead = b2da_pkg::NUM_DIGITS - 1;
            for (int k = b2da_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
                if (dig[k] != 4'd0) begin
                    lead = k;
                end
            end
            for (int k = lead; k < b2da_pkg::NUM_DIGITS; k++) begin
                chars_due.push_back('{b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(dig[k]),
                                      k == b2da_pkg::NUM_DIGITS - 1});
            end
        end
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            chars_due.push_back('{b2da_pkg::CHAR_W'(s[i]), i == s.len() - 1});
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [b2da_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1:       return b2da_pkg::VALUE_W'($urandom_range(0, 9));
            2:       return b2da_pkg::VALUE_W'($urandom_range(10, 99));
            3:       return b2da_pkg::VALUE_W'($urandom_range(100, 999));
            4:       return b2da_pkg::VALUE_W'($urandom_range(1000, 9999));
            default: return b2da_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic void add_row(input logic c, input logic [b2da_pkg::VALUE_W-1:0] d,
                                    input string t);
        dir_rows.push_back('{c, d, t});
    endfunction

    // called at a rising edge; returns at the edge where the value transaction happens
    task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v, input string txt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        if (txt.len() != 0) begin
            queue_text(txt);
        end else begin
            predict_text(v, fmt_mode);
        end
        values_sent++;
    endtask

    task automatic write_format(input logic m);
        i_valid <= 1'b0;
        while (chars_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        fmt_mode = m;
        cfg_writes++;
    endtask

    // output side: random backpressure and checking
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else begin
            sink_draw = $urandom_range(0, 99);
            if (calm || sink_draw < 75) begin
                i_ready <= 1'b1;
            end else if (sink_draw < 95) begin
                stall_left <= $urandom_range(0, 2);
                i_ready    <= 1'b0;
            end else begin
                stall_left <= $urandom_range(5, 30);
                i_ready    <= 1'b0;
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected char 0x%02h last %0b", $time, o_char_code, o_last);
                errors++;
            end else begin
                if (o_char_code !== chars_due[0].code) begin
                    $display("%0t: char_code expected 0x%02h, got 0x%02h",
                             $time, chars_due[0].code, o_char_code);
                    errors++;
                end
                if (o_last !== chars_due[0].last) begin
                    $display("%0t: last expected %0b, got %0b",
                             $time, chars_due[0].last, o_last);
                    errors++;
                end
                void'(chars_due.pop_front());
                chars_checked++;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = b2da_pkg::MODE_MINIMAL;
        fmt_mode    = b2da_pkg::MODE_MINIMAL;
        calm        = 1'b0;
        errors      = 0;
        stall_left  = 0;

        // reset default is minimal
        add_row(1'b0, 16'd0,     "0");
        add_row(1'b0, 16'd7,     "7");
        add_row(1'b0, 16'd9,     "9");
        add_row(1'b0, 16'd10,    "10");
        add_row(1'b0, 16'd99,    "99");
        add_row(1'b0, 16'd100,   "100");
        add_row(1'b0, 16'd1000,  "1000");
        add_row(1'b0, 16'd9999,  "9999");
        add_row(1'b0, 16'd10000, "10000");
        add_row(1'b0, 16'd65535, "65535");
        add_row(1'b0, 16'd12345, "");
        add_row(1'b0, 16'hAAAA,  "");
        add_row(1'b0, 16'h5555,  "");
        add_row(1'b1, 16'(b2da_pkg::MODE_PADDED), "");
        add_row(1'b0, 16'd0,     " 00000 ");
        add_row(1'b0, 16'd65535, " 65535 ");
        add_row(1'b0, 16'd7,     " 00007 ");
        add_row(1'b0, 16'd40960, "");
        add_row(1'b0, 16'd12345, "");
        add_row(1'b1, 16'(b2da_pkg::MODE_MINIMAL), "");
        add_row(1'b0, 16'd1,     "1");
        add_row(1'b0, 16'd32768, "32768");
        add_row(1'b0, 16'd500,   "500");

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].ch) begin
                write_format(dir_rows[i].data[0]);
            end else begin
                send_value(dir_rows[i].data, dir_rows[i].text);
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            if (ph < 4) begin
                write_format((ph % 2 == 0) ? b2da_pkg::MODE_PADDED : b2da_pkg::MODE_MINIMAL);
            end else begin
                write_format(logic'($urandom_range(0, 1)));
            end
            calm = (ph == 2);
            repeat (28) send_value(rand_value(), "");
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (chars_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Converted %0d values in both formats, %0d characters checked,",
                 values_sent, chars_checked);
        $display("with %0d format writes between quiet phases.", cfg_writes);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
